// File: rtl/core/assert_macros.svh
// Assertion helpers for the cache directory. Define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked on aclk out of reset
`define ASSERT_IMP(lbl, ant, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (con)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (con)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, ant, con, msg)
`define ASSERT_NXT(lbl, ant, con, msg)
`endif
`endif

// File: rtl/core/lbcd_pkg.sv
// ----------------------------------------------------------------------------
// lbcd_pkg
// Shared types and constants of the LRU block cache directory.
// ----------------------------------------------------------------------------
package lbcd_pkg;

    localparam int          SLOTS_DEF  = 64;
    localparam logic [31:0] ARENA_RST  = 32'd4096;
    localparam logic [31:0] DEV_CACHED = 32'd1;
    localparam int          PADDR_W    = 3;
    localparam logic        REG_ARENA  = 1'b0;

    localparam logic [1:0] CMD_GET   = 2'd0;
    localparam logic [1:0] CMD_MARK  = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    localparam logic [2:0] ST_HIT    = 3'd0;
    localparam logic [2:0] ST_MISS   = 3'd1;
    localparam logic [2:0] ST_REJECT = 3'd2;
    localparam logic [2:0] ST_MARK   = 3'd3;
    localparam logic [2:0] ST_WB     = 3'd4;
    localparam logic [2:0] ST_NONE   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE, S_DISP, S_SCAN, S_GDONE, S_FSCAN, S_FREAD, S_ONE
    } state_t;

    typedef enum logic [1:0] {EM_NONE, EM_ONE, EM_GET, EM_WB} emit_t;

    typedef struct packed {
        logic  latch;
        logic  clr;
        logic  step;
        logic  fnext;
        emit_t emit;
    } dp_cmd_t;

    typedef struct packed {
        logic go_get;
        logic go_flush;
        logic scan_done;
        logic fvd;
        logic fend;
        logic sent;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/core/lbcd_ram.sv
// ----------------------------------------------------------------------------
// lbcd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lbcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/core/lbcd_ctrl.sv
// ----------------------------------------------------------------------------
// lbcd_ctrl
// Sequencer: dispatches each word to lookup, flush walk or single reply.
// ----------------------------------------------------------------------------
module lbcd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  lbcd_pkg::dp_stat_t st,
    output lbcd_pkg::dp_cmd_t  ctl
);
    import lbcd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        ctl.emit   = EM_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.latch  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (st.go_get) begin
                    ctl.clr    = 1'b1;
                    state_next = S_SCAN;
                end else if (st.go_flush) begin
                    ctl.clr    = 1'b1;
                    state_next = S_FSCAN;
                end else begin
                    state_next = S_ONE;
                end
            end
            S_SCAN: begin
                if (st.scan_done) begin
                    state_next = S_GDONE;
                end else begin
                    ctl.step = 1'b1;
                end
            end
            S_GDONE: begin
                if (st.out_free) begin
                    ctl.emit   = EM_GET;
                    state_next = S_IDLE;
                end
            end
            S_FSCAN: begin
                if (st.fend) begin
                    state_next = st.sent ? S_IDLE : S_ONE;
                end else if (st.fvd) begin
                    state_next = S_FREAD;   // tag read lands next cycle
                end else begin
                    ctl.fnext = 1'b1;
                end
            end
            S_FREAD: begin
                if (st.out_free) begin
                    ctl.emit   = EM_WB;
                    state_next = S_FSCAN;
                end
            end
            S_ONE: begin
                if (st.out_free) begin
                    ctl.emit   = EM_ONE;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// File: rtl/core/lbcd_dp.sv
// ----------------------------------------------------------------------------
// lbcd_dp
// Directory datapath: slot flags, tag/stamp RAMs, scan trackers, result reg.
// ----------------------------------------------------------------------------
module lbcd_dp #(
    parameter int SLOTS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lbcd_pkg::dp_cmd_t  ctl,
    output lbcd_pkg::dp_stat_t st,
    input  logic [31:0]        arena_blocks,
    input  logic [1:0]         in_cmd,
    input  logic [31:0]        in_blk,
    input  logic [31:0]        in_dev,
    input  logic [5:0]         in_slot_index,
    input  logic               in_slot_present,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [2:0]         out_status,
    output logic [5:0]         out_slot,
    output logic [31:0]        out_fill_block,
    output logic               out_writeback,
    output logic [31:0]        out_writeback_block,
    output logic               out_last
);
    import lbcd_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = IW + 1;

    // latched request
    logic [1:0]  cmd_reg;
    logic [31:0] blk_reg, dev_reg;
    logic [5:0]  sidx_reg;
    logic        spres_reg;

    logic [SLOTS-1:0] valid_reg, dirty_reg;
    logic [31:0]      ctr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             pv_reg, hit_f_reg, free_f_reg, sent_reg;
    logic [IW-1:0]    pidx_reg, hit_idx_reg, free_idx_reg, min_idx_reg;
    logic [31:0]      min_stamp_reg, min_tag_reg;

    logic        ov_reg, olast_reg, owb_reg;
    logic [2:0]  ostat_reg;
    logic [5:0]  oslot_reg;
    logic [31:0] ofill_reg, owblk_reg;

    logic [31:0]   tag_q, stamp_q, tick;
    logic [IW-1:0] raddr, vic;
    logic          more, cnt_lt, miss_wb, mark_ok, out_free;

    assign tick   = ctr_reg + 32'd1;
    assign raddr  = cnt_reg[IW-1:0];
    assign cnt_lt = (cnt_reg < CW'(SLOTS));
    assign vic    = hit_f_reg ? hit_idx_reg : (free_f_reg ? free_idx_reg : min_idx_reg);
    assign miss_wb = !hit_f_reg && !free_f_reg && dirty_reg[min_idx_reg];
    assign mark_ok = spres_reg && (32'(sidx_reg) < 32'(SLOTS));
    assign out_free = !ov_reg || out_ready;

    // any further dirty slot past the flush cursor decides tlast
    always_comb begin
        more = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            more = more | ((CW'(j) > cnt_reg) & valid_reg[j] & dirty_reg[j]);
        end
    end

    lbcd_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_tag (
        .aclk(aclk), .we(ctl.emit == EM_GET && !hit_f_reg), .waddr(vic),
        .wdata(blk_reg), .raddr(raddr), .rdata(tag_q)
    );

    lbcd_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_stamp (
        .aclk(aclk), .we(ctl.emit == EM_GET), .waddr(vic),
        .wdata(tick), .raddr(raddr), .rdata(stamp_q)
    );

    always_comb begin
        st.go_get    = (cmd_reg == CMD_GET) && (dev_reg == DEV_CACHED)
                       && (blk_reg < arena_blocks);
        st.go_flush  = (cmd_reg == CMD_FLUSH) && (dev_reg == DEV_CACHED);
        st.scan_done = !cnt_lt && !pv_reg;
        st.fend      = !cnt_lt;
        st.fvd       = cnt_lt && valid_reg[raddr] && dirty_reg[raddr];
        st.sent      = sent_reg;
        st.out_free  = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            dirty_reg  <= '0;
            ctr_reg    <= '0;
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            hit_f_reg  <= 1'b0;
            free_f_reg <= 1'b0;
            sent_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            if (ctl.emit != EM_NONE) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
            if (ctl.clr) begin
                cnt_reg    <= '0;
                pv_reg     <= 1'b0;
                hit_f_reg  <= 1'b0;
                free_f_reg <= 1'b0;
                sent_reg   <= 1'b0;
            end
            if (ctl.step) begin
                pv_reg <= cnt_lt;
                if (cnt_lt) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (pv_reg) begin
                    if (valid_reg[pidx_reg] && tag_q == blk_reg && !hit_f_reg) begin
                        hit_f_reg <= 1'b1;
                    end
                    if (!valid_reg[pidx_reg] && !free_f_reg) begin
                        free_f_reg <= 1'b1;
                    end
                end
            end
            if (ctl.fnext) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            case (ctl.emit)
                EM_GET: begin
                    ctr_reg        <= tick;
                    valid_reg[vic] <= 1'b1;
                    if (!hit_f_reg) begin
                        dirty_reg[vic] <= 1'b0;
                    end
                end
                EM_ONE: begin
                    if (cmd_reg == CMD_MARK && mark_ok) begin
                        dirty_reg[IW'(sidx_reg)] <= 1'b1;
                    end
                end
                EM_WB: begin
                    dirty_reg[raddr] <= 1'b0;
                    cnt_reg          <= cnt_reg + CW'(1);
                    sent_reg         <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // payload: request latch, scan trackers, result fields
    always_ff @(posedge aclk) begin
        if (ctl.latch) begin
            cmd_reg   <= in_cmd;
            blk_reg   <= in_blk;
            dev_reg   <= in_dev;
            sidx_reg  <= in_slot_index;
            spres_reg <= in_slot_present;
        end
        if (ctl.step) begin
            if (cnt_lt) begin
                pidx_reg <= raddr;
            end
            if (pv_reg) begin
                if (valid_reg[pidx_reg] && tag_q == blk_reg && !hit_f_reg) begin
                    hit_idx_reg <= pidx_reg;
                end
                if (!valid_reg[pidx_reg] && !free_f_reg) begin
                    free_idx_reg <= pidx_reg;
                end
                // strict less-than keeps the lowest slot on a tie
                if (pidx_reg == '0 || stamp_q < min_stamp_reg) begin
                    min_stamp_reg <= stamp_q;
                    min_idx_reg   <= pidx_reg;
                    min_tag_reg   <= tag_q;
                end
            end
        end
        case (ctl.emit)
            EM_GET: begin
                ostat_reg <= hit_f_reg ? ST_HIT : ST_MISS;
                oslot_reg <= 6'(vic);
                ofill_reg <= hit_f_reg ? 32'd0 : blk_reg;
                owb_reg   <= miss_wb;
                owblk_reg <= miss_wb ? min_tag_reg : 32'd0;
                olast_reg <= 1'b1;
            end
            EM_ONE: begin
                if (cmd_reg == CMD_MARK) begin
                    ostat_reg <= ST_MARK;
                    oslot_reg <= spres_reg ? sidx_reg : 6'd0;
                end else if (cmd_reg == CMD_FLUSH) begin
                    ostat_reg <= ST_NONE;
                    oslot_reg <= 6'd0;
                end else begin
                    ostat_reg <= ST_REJECT;
                    oslot_reg <= 6'd0;
                end
                ofill_reg <= 32'd0;
                owb_reg   <= 1'b0;
                owblk_reg <= 32'd0;
                olast_reg <= 1'b1;
            end
            EM_WB: begin
                ostat_reg <= ST_WB;
                oslot_reg <= 6'(raddr);
                ofill_reg <= 32'd0;
                owb_reg   <= 1'b1;
                owblk_reg <= tag_q;
                olast_reg <= !more;
            end
            default: begin
            end
        endcase
    end

    assign out_valid           = ov_reg;
    assign out_status          = ostat_reg;
    assign out_slot            = oslot_reg;
    assign out_fill_block      = ofill_reg;
    assign out_writeback       = owb_reg;
    assign out_writeback_block = owblk_reg;
    assign out_last            = olast_reg;
endmodule

// File: rtl/core/lru_block_cache_directory_unit.sv
// A get result is registered after a scan of the tag and stamp RAMs (one RAM read per slot);
// mark and rejects are registered after the dispatch and single-reply states.
// Flush walks every slot once and emits a writeback word for each valid dirty slot.
// One word is in flight at a time; the next is accepted once its result is registered.
// Reset (aresetn low, synchronous) frees all slots, clears dirty bits and the counter,
// and sets arena_blocks to 4096.
// ----------------------------------------------------------------------------
// lru_block_cache_directory_unit
// Fully associative tag directory with LRU replacement and dirty flush.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lru_block_cache_directory_unit #(
    parameter int SLOTS = lbcd_pkg::SLOTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [31:0] block, [63:32] device, [69:64] slot_index, [70] slot_present
    input  logic [71:0]                  s_tdata,
    // [1:0] cmd
    input  logic [1:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [5:0] slot, [37:6] fill_block, [38] writeback, [70:39] writeback_block
    output logic [71:0]                  m_tdata,
    // [2:0] status
    output logic [2:0]                   m_tuser,
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lbcd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import lbcd_pkg::*;

    dp_cmd_t     ctl;
    dp_stat_t    st;
    logic [31:0] arena_reg;
    logic [5:0]  o_slot;
    logic [31:0] o_fill, o_wblk;
    logic        o_wb;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ARENA) ? arena_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arena_reg <= ARENA_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ARENA) begin
            arena_reg <= pwdata;
        end
    end

    lbcd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .st(st), .ctl(ctl)
    );

    lbcd_dp #(.SLOTS(SLOTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .st(st),
        .arena_blocks(arena_reg),
        .in_cmd(s_tuser), .in_blk(s_tdata[31:0]), .in_dev(s_tdata[63:32]),
        .in_slot_index(s_tdata[69:64]), .in_slot_present(s_tdata[70]),
        .out_ready(m_tready), .out_valid(m_tvalid), .out_status(m_tuser),
        .out_slot(o_slot), .out_fill_block(o_fill), .out_writeback(o_wb),
        .out_writeback_block(o_wblk), .out_last(m_tlast)
    );

    assign m_tdata = {1'b0, o_wblk, o_wb, o_fill, o_slot};

    `ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second word accepted early")
    `ASSERT_IMP(a_emit_free, ctl.emit != EM_NONE, st.out_free, "result reg overwritten")
    `ASSERT_IMP(a_single_last, m_tvalid && m_tuser != ST_WB, m_tlast, "single result lacks last")
    `ASSERT_IMP(a_wb_flag, m_tvalid && m_tuser == ST_WB, m_tdata[38], "flush word without writeback")
endmodule

// File: bench/lru_block_cache_directory_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU block cache directory testbench
// Drives get, mark-dirty, flush and unused-command words into the directory and predicts
// every result from its own copy of the tags, stamps, dirty bits and counter.
// Results are checked in order, field by field, under random back-pressure.
// ----------------------------------------------------------------------------
module lru_block_cache_directory_unit_tb;
    import lbcd_pkg::*;

    localparam int NSLOT      = SLOTS_DEF;
    localparam int WDOG_LIMIT = 200000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [31:0] fill_block;
        logic        writeback;
        logic [31:0] wb_block;
        logic        last;
    } dir_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lru_block_cache_directory_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic [31:0] arena_blocks;
    logic        dir_valid [NSLOT];
    logic [31:0] dir_tag   [NSLOT];
    logic [31:0] dir_stamp [NSLOT];
    logic        dir_dirty [NSLOT];
    logic [31:0] access_count;

    dir_result_t pending_results[$];
    int unsigned errors = 0;
    int unsigned n_words = 0, n_results = 0, n_wb = 0, n_evict = 0;
    int unsigned send_idle = 11, recv_idle = 84;
    int unsigned quiet_cycles = 0;

    function automatic dir_result_t mk(logic [2:0] st, logic [5:0] sl, logic [31:0] fb,
                                       logic wb, logic [31:0] wbb, logic lst);
        dir_result_t r;
        r.status = st; r.slot = sl; r.fill_block = fb;
        r.writeback = wb; r.wb_block = wbb; r.last = lst;
        return r;
    endfunction

    task automatic predict_directory(logic [1:0] cmd, logic [31:0] blk, logic [31:0] dev,
                                     logic [5:0] sidx, logic spres);
        int victim;
        int first;
        logic [31:0] minv;
        logic wb;
        logic [31:0] wbb;
        victim = -1;
        first = -1;
        wb = 1'b0;
        wbb = '0;
        case (cmd)
            CMD_GET: begin
                if (dev != DEV_CACHED || blk >= arena_blocks) begin
                    pending_results.push_back(mk(ST_REJECT, 0, 0, 0, 0, 1));
                    return;
                end
                access_count++;
                for (int i = 0; i < NSLOT; i++)
                    if (victim < 0 && dir_valid[i] && dir_tag[i] == blk) victim = i;
                if (victim >= 0) begin
                    dir_stamp[victim] = access_count;
                    pending_results.push_back(mk(ST_HIT, victim[5:0], 0, 0, 0, 1));
                    return;
                end
                for (int i = 0; i < NSLOT; i++)
                    if (first < 0 && !dir_valid[i]) first = i;
                if (first < 0) begin
                    first = 0;
                    minv = dir_stamp[0];
                    for (int i = 1; i < NSLOT; i++)
                        if (dir_stamp[i] < minv) begin
                            minv = dir_stamp[i];
                            first = i;
                        end
                    n_evict++;
                end
                if (dir_valid[first] && dir_dirty[first]) begin
                    wb = 1'b1;
                    wbb = dir_tag[first];
                end
                dir_valid[first] = 1'b1;
                dir_tag[first] = blk;
                dir_stamp[first] = access_count;
                dir_dirty[first] = 1'b0;
                pending_results.push_back(mk(ST_MISS, first[5:0], blk, wb, wbb, 1));
            end
            CMD_MARK: begin
                if (!spres) begin
                    pending_results.push_back(mk(ST_MARK, 0, 0, 0, 0, 1));
                end else begin
                    dir_dirty[sidx] = 1'b1;
                    pending_results.push_back(mk(ST_MARK, sidx, 0, 0, 0, 1));
                end
            end
            CMD_FLUSH: begin
                int n;
                n = 0;
                if (dev == DEV_CACHED)
                    for (int i = 0; i < NSLOT; i++)
                        if (dir_valid[i] && dir_dirty[i]) begin
                            pending_results.push_back(mk(ST_WB, i[5:0], 0, 1, dir_tag[i], 0));
                            dir_dirty[i] = 1'b0;
                            n++;
                        end
                if (n == 0) pending_results.push_back(mk(ST_NONE, 0, 0, 0, 0, 1));
                else pending_results[$].last = 1'b1;
            end
            default: pending_results.push_back(mk(ST_REJECT, 0, 0, 0, 0, 1));
        endcase
    endtask

    task automatic send_word(logic [1:0] cmd, logic [31:0] blk, logic [31:0] dev,
                             logic [5:0] sidx, logic spres);
        while ($urandom_range(99) < send_idle) @(posedge aclk);
        predict_directory(cmd, blk, dev, sidx, spres);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, spres, sidx, dev, blk};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s_tvalid <= 1'b0;
        n_words++;
        // the block is busy after accepting, so nothing is lost here
        @(posedge aclk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (NSLOT * 3 + 10) @(posedge aclk);
    endtask

    task automatic write_arena(logic [31:0] value);
        logic [31:0] rd;
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        psel <= 1'b0; penable <= 1'b0;
        arena_blocks = value;
        if (rd !== value) begin
            $error("arena_blocks readback: expected %h actual %h", value, rd);
            errors++;
        end
    endtask

    // checker
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                dir_result_t got, exp;
                got = mk(m_tuser, m_tdata[5:0], m_tdata[37:6], m_tdata[38],
                         m_tdata[70:39], m_tlast);
                n_results++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result word: status %0d slot %0d", m_tuser,
                           m_tdata[5:0]);
                    errors++;
                end else begin
                    exp = pending_results.pop_front();
                    if (got.writeback && got.status == ST_WB) n_wb++;
                    if (got.status !== exp.status) begin
                        $error("status: expected %0d actual %0d", exp.status, got.status);
                        errors++;
                    end
                    if (got.slot !== exp.slot) begin
                        $error("slot: expected %0d actual %0d", exp.slot, got.slot);
                        errors++;
                    end
                    if (got.fill_block !== exp.fill_block) begin
                        $error("fill_block: expected %h actual %h", exp.fill_block,
                               got.fill_block);
                        errors++;
                    end
                    if (got.writeback !== exp.writeback) begin
                        $error("writeback: expected %0d actual %0d", exp.writeback,
                               got.writeback);
                        errors++;
                    end
                    if (got.wb_block !== exp.wb_block) begin
                        $error("writeback_block: expected %h actual %h", exp.wb_block,
                               got.wb_block);
                        errors++;
                    end
                    if (got.last !== exp.last) begin
                        $error("last: expected %0d actual %0d", exp.last, got.last);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog: cycles with no accepted word on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_directed();
        // rejects: wrong device, block at and above the arena limit, unused command
        send_word(CMD_GET, 32'd5, 32'd0, 0, 0);
        send_word(CMD_GET, 32'd5, 32'hFFFF_FFFF, 0, 0);
        send_word(CMD_GET, ARENA_RST, DEV_CACHED, 0, 0);
        send_word(CMD_GET, 32'hFFFF_FFFF, DEV_CACHED, 0, 0);
        send_word(CMD_UNUSED, 32'd1, DEV_CACHED, 6'h3F, 1);
        // flush with nothing dirty
        send_word(CMD_FLUSH, 0, DEV_CACHED, 0, 0);
        // fill, hit, mark, flush
        send_word(CMD_GET, 32'd0, DEV_CACHED, 0, 0);
        send_word(CMD_GET, ARENA_RST - 1, DEV_CACHED, 0, 0);
        send_word(CMD_GET, 32'd0, DEV_CACHED, 0, 0);
        send_word(CMD_MARK, 0, 0, 6'd0, 1);
        send_word(CMD_MARK, 0, 0, 6'h3F, 0);  // no slot named
        send_word(CMD_MARK, 0, 0, 6'h3F, 1);  // free slot
        send_word(CMD_FLUSH, 0, 32'd2, 0, 0); // other device
        send_word(CMD_FLUSH, 0, DEV_CACHED, 0, 0);
        send_word(CMD_MARK, 0, 0, 6'd1, 1);
        send_word(CMD_FLUSH, 0, DEV_CACHED, 0, 0);
    endtask

    task automatic test_lru_eviction();
        // fill every slot, dirty a few, then overflow to force dirty victims
        for (int i = 0; i < NSLOT; i++) send_word(CMD_GET, 32'd100 + i, DEV_CACHED, 0, 0);
        send_word(CMD_GET, 32'd100, DEV_CACHED, 0, 0);
        for (int i = 0; i < 4; i++) send_word(CMD_MARK, 0, 0, i[5:0], 1);
        for (int i = 0; i < 6; i++) send_word(CMD_GET, 32'd300 + i, DEV_CACHED, 0, 0);
    endtask

    task automatic test_random(int unsigned count, logic [31:0] span);
        logic [1:0] cmd;
        logic [31:0] blk, dev;
        int unsigned r;
        for (int unsigned k = 0; k < count; k++) begin
            r = $urandom_range(99);
            cmd = (r < 65) ? CMD_GET : (r < 88) ? CMD_MARK : (r < 96) ? CMD_FLUSH
                                                                       : CMD_UNUSED;
            blk = ($urandom_range(9) == 0) ? $urandom : $urandom_range(span);
            dev = ($urandom_range(11) == 0) ? $urandom : DEV_CACHED;
            send_word(cmd, blk, dev, 6'($urandom_range(63)), ($urandom_range(7) != 0));
        end
    endtask

    initial begin
        arena_blocks = ARENA_RST;
        access_count = '0;
        for (int i = 0; i < NSLOT; i++) begin
            dir_valid[i] = 0; dir_tag[i] = 0; dir_stamp[i] = 0; dir_dirty[i] = 0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        drain_results();
        write_arena(32'hFFFF_FFFF);
        test_lru_eviction();
        test_random(20, 32'd90);
        drain_results();  // sender holds off until every result is in

        send_idle = 84; recv_idle = 11;
        write_arena(32'd0);
        send_word(CMD_GET, 32'd0, DEV_CACHED, 0, 0);
        send_word(CMD_FLUSH, 0, DEV_CACHED, 0, 0);
        drain_results();
        write_arena(32'd80);
        test_random(20, 32'd100);
        drain_results();

        send_idle = 0; recv_idle = 0;
        write_arena(32'hFFFF_FFFF);
        test_random(12, 32'hFFFF_FFFF);
        test_random(6, 32'd40);
        send_word(CMD_FLUSH, 0, DEV_CACHED, 0, 0);
        drain_results();

        $display("Sent %0d words, checked %0d results (%0d flush writebacks, %0d LRU evictions)",
                 n_words, n_results, n_wb, n_evict);
        $display("Arena limit swept over 4096, 0, 80 and 2^32-1 with varied back-pressure.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
